// ----- hdl/pfpg_pkg.sv -----
// shared types and constants of the potential field pattern generator
`default_nettype none

package pfpg_pkg;

    // coordinate width: x and y of any cell for any supported grid size
    localparam int CW   = 25;
    // squared distance width, q32
    localparam int DW   = 48;
    // square root argument and result widths
    localparam int SQIW = 54;
    localparam int SQOW = 27;
    // reciprocal quotient width, anything wider is clamped
    localparam int QW   = 24;
    // multiplier operand width next to strength
    localparam int MW   = 32;
    // slit compare width, holds twice a coordinate
    localparam int CMPW = 27;
    // potential width
    localparam int PW   = 32;
    // config index width
    localparam int RIW  = 3;

    // numerator of the reciprocal is 2^RECIP_SH
    localparam int RECIP_SH = 32;
    // a root at or below this gives a quotient of 2^24 or more
    localparam int RECIP_BIG_Q = 256;

    typedef enum logic [3:0] {
        MODE_ZERO        = 4'd0,
        MODE_HARMONIC    = 4'd1,
        MODE_DOUBLE_SLIT = 4'd2,
        MODE_SINGLE_SLIT = 4'd3,
        MODE_STEP        = 4'd4,
        MODE_INV_R       = 4'd5,
        MODE_TRIPLE      = 4'd6,
        MODE_NEG_INV_R   = 4'd7,
        MODE_CIRCLE      = 4'd8,
        MODE_CONE        = 4'd9
    } mode_t;

    typedef enum logic [RIW-1:0] {
        REG_MODE              = 3'd0,
        REG_STRENGTH          = 3'd1,
        REG_BARRIER_CENTER_Y  = 3'd2,
        REG_BARRIER_THICKNESS = 3'd3,
        REG_GAP_OR_RADIUS     = 3'd4,
        REG_FIRST_SLIT_X      = 3'd5,
        REG_SECOND_SLIT_X     = 3'd6
    } reg_index_t;

    // clamp magnitudes and fixed levels, q16.16
    localparam logic [PW-1:0]        INVR_CAP    = 32'd3276800;
    localparam logic [PW-1:0]        NEGINVR_CAP = 32'd9830400;
    localparam logic signed [PW-1:0] TRIPLE_VAL  = 32'sd983040;

    // triple slit wall band and openings, q0.16
    localparam logic signed [CW-1:0] TRI_Y_LO  = 25'sd29491;
    localparam logic signed [CW-1:0] TRI_Y_HI  = 25'sd31457;
    localparam logic signed [CW-1:0] TRI_XC_LO = 25'sd32113;
    localparam logic signed [CW-1:0] TRI_XC_HI = 25'sd33423;
    localparam logic signed [CW-1:0] TRI_XL_LO = 25'sd28180;
    localparam logic signed [CW-1:0] TRI_XL_HI = 25'sd29491;
    localparam logic signed [CW-1:0] TRI_XR_LO = 25'sd36045;
    localparam logic signed [CW-1:0] TRI_XR_HI = 25'sd37356;

    // what travels beside the root and quotient
    typedef struct packed {
        logic [7:0]             row;
        logic [7:0]             col;
        logic                   fixed_sel;
        logic signed [PW-1:0]   fixed_val;
        logic [MW-1:0]          hm;
    } side_t;

endpackage

`default_nettype wire

// ----- hdl/pfpg_isqrt.sv -----
// pipelined floor square root, one result bit per stage
`default_nettype none

module pfpg_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [pfpg_pkg::SQIW-1:0]   arg,
    input  wire pfpg_pkg::side_t             in_side,
    output logic                             out_valid,
    output logic [pfpg_pkg::SQOW-1:0]        root,
    output pfpg_pkg::side_t                  out_side
);

    localparam int N  = pfpg_pkg::SQOW;
    localparam int IW = pfpg_pkg::SQIW;
    localparam int TW = pfpg_pkg::SQIW + 2;

    logic                   vld_reg  [N];
    logic [IW-1:0]          rem_reg  [N];
    logic [N-1:0]           root_reg [N];
    pfpg_pkg::side_t        side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam int K = N - 1 - i;

        logic               v_in;
        logic [IW-1:0]      rem_in;
        logic [N-1:0]       root_in;
        pfpg_pkg::side_t    side_in;
        logic [TW-1:0]      trial;
        logic               take;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = arg;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // (root + 2^k)^2 - root^2
        assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? IW'(TW'(rem_in) - trial) : rem_in;
                root_reg[i] <= take ? (root_in | (N'(1) << K)) : root_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ----- hdl/pfpg_recip.sv -----
// pipelined reciprocal 2^32 / q, one quotient bit per stage
`default_nettype none

module pfpg_recip (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [pfpg_pkg::SQOW-1:0]   q,
    input  wire pfpg_pkg::side_t             in_side,
    output logic                             out_valid,
    output logic [pfpg_pkg::SQOW-1:0]        out_q,
    output logic [pfpg_pkg::QW-1:0]          quot,
    output logic                             big,
    output pfpg_pkg::side_t                  out_side
);

    localparam int N  = pfpg_pkg::QW;
    localparam int QB = pfpg_pkg::SQOW;
    localparam int RW = pfpg_pkg::SQOW + pfpg_pkg::QW;

    logic                   vld_reg  [N];
    logic [RW-1:0]          rem_reg  [N];
    logic [N-1:0]           quot_reg [N];
    logic [QB-1:0]          q_reg    [N];
    logic                   big_reg  [N];
    pfpg_pkg::side_t        side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam int K = N - 1 - i;

        logic               v_in;
        logic [RW-1:0]      rem_in;
        logic [N-1:0]       quot_in;
        logic [QB-1:0]      q_in;
        logic               big_in;
        pfpg_pkg::side_t    side_in;
        logic [RW-1:0]      dsh;
        logic               take;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = RW'(1) << pfpg_pkg::RECIP_SH;
            assign quot_in = '0;
            assign q_in    = q;
            // small roots (zero too) saturate the quotient, clamp later
            assign big_in  = q <= QB'(pfpg_pkg::RECIP_BIG_Q);
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign big_in  = big_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign dsh  = RW'(q_in) << K;
        assign take = rem_in >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? (rem_in - dsh) : rem_in;
                quot_reg[i] <= take ? (quot_in | (N'(1) << K)) : quot_in;
                q_reg[i]    <= q_in;
                big_reg[i]  <= big_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_q     = q_reg[N-1];
    assign quot      = quot_reg[N-1];
    assign big       = big_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ----- hdl/potential_field_pattern_generator_unit.sv -----
// top level of the potential field pattern generator
`default_nettype none

// Potential field pattern generator. Each transaction on the input channel
// carries one grid cell (row, col); the block maps the cell centre to
// unit-square coordinates and returns the cell's potential, signed q16.16
// and saturated, for the mode held in the config registers, together with
// the echoed row and column. One cell enters per clock unless a result is
// stalled, and results leave in order. The pipeline runs through three
// front stages (coordinates, squares, distance and argument select), a
// 27-stage square root, a 24-stage reciprocal divider and two back stages
// (multiply by strength, then shift and saturate). The whole pipeline moves
// as one: when the output register holds an untaken result, every stage and
// the input channel wait, so nothing is lost or repeated. Config writes
// (always ready) also reach items in flight and are meant for an idle
// block. Grid sizes must be powers of two.

module potential_field_pattern_generator_unit #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   row,
    input  wire logic [7:0]                   col,

    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        cell_row,
    output logic [7:0]                        cell_col,
    output logic signed [pfpg_pkg::PW-1:0]    potential,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [pfpg_pkg::RIW-1:0]     cfg_index,
    input  wire logic [31:0]                  cfg_data
);

    localparam int CW   = pfpg_pkg::CW;
    localparam int DW   = pfpg_pkg::DW;
    localparam int SQIW = pfpg_pkg::SQIW;
    localparam int SQOW = pfpg_pkg::SQOW;
    localparam int QW   = pfpg_pkg::QW;
    localparam int MW   = pfpg_pkg::MW;
    localparam int CMPW = pfpg_pkg::CMPW;
    localparam int PW   = pfpg_pkg::PW;
    localparam int PRW  = PW + MW + 1;

    // divide by twice the grid size is a right shift
    localparam int XSH = $clog2(GRID_WIDTH) + 1;
    localparam int YSH = $clog2(GRID_HEIGHT) + 1;

    localparam logic signed [PRW-1:0] SAT_HI = PRW'(2147483647);
    localparam logic signed [PRW-1:0] SAT_LO = -SAT_HI - PRW'(1);

    // ---------------------------------------------------------------
    // config registers
    // ---------------------------------------------------------------
    logic [3:0]             mode_reg;
    logic signed [PW-1:0]   strength_reg;
    logic [15:0]            barrier_center_y_reg;
    logic [15:0]            barrier_thickness_reg;
    logic [15:0]            gap_or_radius_reg;
    logic [15:0]            first_slit_x_reg;
    logic [15:0]            second_slit_x_reg;
    logic [31:0]            gap_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg              <= '0;
            strength_reg          <= '0;
            barrier_center_y_reg  <= '0;
            barrier_thickness_reg <= '0;
            gap_or_radius_reg     <= '0;
            first_slit_x_reg      <= '0;
            second_slit_x_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pfpg_pkg::REG_MODE:              mode_reg              <= cfg_data[3:0];
                pfpg_pkg::REG_STRENGTH:          strength_reg          <= $signed(cfg_data);
                pfpg_pkg::REG_BARRIER_CENTER_Y:  barrier_center_y_reg  <= cfg_data[15:0];
                pfpg_pkg::REG_BARRIER_THICKNESS: barrier_thickness_reg <= cfg_data[15:0];
                pfpg_pkg::REG_GAP_OR_RADIUS:     gap_or_radius_reg     <= cfg_data[15:0];
                pfpg_pkg::REG_FIRST_SLIT_X:      first_slit_x_reg      <= cfg_data[15:0];
                pfpg_pkg::REG_SECOND_SLIT_X:     second_slit_x_reg     <= cfg_data[15:0];
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // squared radius for the circle well, registered from the radius register
    always_ff @(posedge clk)
    begin
        gap_sq_reg <= 32'(gap_or_radius_reg) * 32'(gap_or_radius_reg);
    end

    // ---------------------------------------------------------------
    // global advance: the pipeline moves unless a result is stuck
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------------------------------------------------------
    // stage 1: cell centre coordinates
    // ---------------------------------------------------------------
    logic                   s1_valid_reg;
    logic [7:0]             s1_row_reg;
    logic [7:0]             s1_col_reg;
    logic signed [CW-1:0]   s1_x_reg;
    logic signed [CW-1:0]   s1_y_reg;

    logic [CW-1:0]          xnum;
    logic [CW-1:0]          ynum;
    logic [CW-1:0]          xu;
    logic [CW-1:0]          yu;

    // (2*idx + 1) << 16, then / (2*size)
    assign xnum = {col, 1'b1, 16'b0};
    assign ynum = {row, 1'b1, 16'b0};
    assign xu   = xnum >> XSH;
    assign yu   = ynum >> YSH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_row_reg <= row;
            s1_col_reg <= col;
            s1_x_reg   <= $signed(xu);
            s1_y_reg   <= CW'(65536) - $signed(yu);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: squares of the offsets from centre, region tests
    // ---------------------------------------------------------------
    logic                   s2_valid_reg;
    logic [7:0]             s2_row_reg;
    logic [7:0]             s2_col_reg;
    logic [DW-1:0]          s2_sqx_reg;
    logic [DW-1:0]          s2_sqy_reg;
    logic                   s2_fixed_sel_reg;
    logic signed [PW-1:0]   s2_fixed_val_reg;

    logic signed [CW-1:0]   dx;
    logic signed [CW-1:0]   dy;
    logic signed [2*CW-1:0] prod_x;
    logic signed [2*CW-1:0] prod_y;

    logic signed [CMPW-1:0] xx2;
    logic signed [CMPW-1:0] yy2;
    logic signed [CMPW-1:0] y0_2;
    logic signed [CMPW-1:0] w_c;
    logic signed [CMPW-1:0] s_c;
    logic signed [CMPW-1:0] x1_2;
    logic signed [CMPW-1:0] x2_2;
    logic signed [CW-1:0]   y0_c;

    logic                   band;
    logic                   left_open;
    logic                   mid_open;
    logic                   right_open;
    logic                   right1_open;
    logic                   tri_zero;

    logic                   fixed_sel_next;
    logic signed [PW-1:0]   fixed_val_next;

    assign dx     = s1_x_reg - CW'(32768);
    assign dy     = s1_y_reg - CW'(32768);
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;

    // twice the coordinates so half thickness and half gap stay exact
    assign xx2  = CMPW'(s1_x_reg) <<< 1;
    assign yy2  = CMPW'(s1_y_reg) <<< 1;
    assign y0_2 = $signed(CMPW'({barrier_center_y_reg, 1'b0}));
    assign w_c  = $signed(CMPW'(barrier_thickness_reg));
    assign s_c  = $signed(CMPW'(gap_or_radius_reg));
    assign x1_2 = $signed(CMPW'({first_slit_x_reg, 1'b0}));
    assign x2_2 = $signed(CMPW'({second_slit_x_reg, 1'b0}));
    assign y0_c = $signed(CW'(barrier_center_y_reg));

    assign band        = (yy2 <= y0_2 + w_c) && (yy2 >= y0_2 - w_c);
    assign left_open   = xx2 <= x1_2 - s_c;
    assign right1_open = xx2 >= x1_2 + s_c;
    assign mid_open    = right1_open && (xx2 <= x2_2 - s_c);
    assign right_open  = xx2 >= x2_2 + s_c;

    // outside the wall band or inside one of the three openings
    assign tri_zero = (s1_y_reg <= pfpg_pkg::TRI_Y_LO) || (s1_y_reg >= pfpg_pkg::TRI_Y_HI) ||
                      ((s1_x_reg > pfpg_pkg::TRI_XC_LO) && (s1_x_reg < pfpg_pkg::TRI_XC_HI)) ||
                      ((s1_x_reg > pfpg_pkg::TRI_XL_LO) && (s1_x_reg < pfpg_pkg::TRI_XL_HI)) ||
                      ((s1_x_reg > pfpg_pkg::TRI_XR_LO) && (s1_x_reg < pfpg_pkg::TRI_XR_HI));

    always_comb
    begin
        fixed_sel_next = 1'b1;
        fixed_val_next = '0;
        case (mode_reg)
            pfpg_pkg::MODE_HARMONIC,
            pfpg_pkg::MODE_INV_R,
            pfpg_pkg::MODE_NEG_INV_R,
            pfpg_pkg::MODE_CIRCLE,
            pfpg_pkg::MODE_CONE:
            begin
                fixed_sel_next = 1'b0;
            end
            pfpg_pkg::MODE_DOUBLE_SLIT:
            begin
                if (band && (left_open || mid_open || right_open))
                begin
                    fixed_val_next = strength_reg;
                end
            end
            pfpg_pkg::MODE_SINGLE_SLIT:
            begin
                if (band && (left_open || right1_open))
                begin
                    fixed_val_next = strength_reg;
                end
            end
            pfpg_pkg::MODE_STEP:
            begin
                if (s1_y_reg > y0_c)
                begin
                    fixed_val_next = strength_reg;
                end
            end
            pfpg_pkg::MODE_TRIPLE:
            begin
                if (!tri_zero)
                begin
                    fixed_val_next = pfpg_pkg::TRIPLE_VAL;
                end
            end
            default:
            begin
                // zero mode and unused codes
                fixed_val_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_row_reg       <= s1_row_reg;
            s2_col_reg       <= s1_col_reg;
            s2_sqx_reg       <= DW'($unsigned(prod_x));
            s2_sqy_reg       <= DW'($unsigned(prod_y));
            s2_fixed_sel_reg <= fixed_sel_next;
            s2_fixed_val_reg <= fixed_val_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: squared distance, root argument, circle test
    // ---------------------------------------------------------------
    logic                   s3_valid_reg;
    logic [SQIW-1:0]        s3_arg_reg;
    pfpg_pkg::side_t        s3_side_reg;

    logic [DW-1:0]          dist_sq;
    logic [SQIW-1:0]        arg_next;
    pfpg_pkg::side_t        side_next;

    assign dist_sq = s2_sqx_reg + s2_sqy_reg;

    always_comb
    begin
        case (mode_reg)
            pfpg_pkg::MODE_INV_R:     arg_next = SQIW'(dist_sq) * SQIW'(100);
            pfpg_pkg::MODE_NEG_INV_R: arg_next = SQIW'(dist_sq) << 2;
            default:                  arg_next = SQIW'(dist_sq);
        endcase
    end

    always_comb
    begin
        side_next.row       = s2_row_reg;
        side_next.col       = s2_col_reg;
        side_next.fixed_sel = s2_fixed_sel_reg;
        side_next.fixed_val = s2_fixed_val_reg;
        side_next.hm        = MW'(dist_sq >> 16);
        if (mode_reg == pfpg_pkg::MODE_CIRCLE)
        begin
            side_next.fixed_sel = 1'b1;
            side_next.fixed_val = (dist_sq < DW'(gap_sq_reg)) ? '0 : strength_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_arg_reg  <= arg_next;
            s3_side_reg <= side_next;
        end
    end

    // ---------------------------------------------------------------
    // square root and reciprocal pipelines
    // ---------------------------------------------------------------
    logic                   sq_valid;
    logic [SQOW-1:0]        sq_root;
    pfpg_pkg::side_t        sq_side;

    logic                   rc_valid;
    logic [SQOW-1:0]        rc_q;
    logic [QW-1:0]          rc_quot;
    logic                   rc_big;
    pfpg_pkg::side_t        rc_side;

    pfpg_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .arg       (s3_arg_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    pfpg_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .q         (sq_root),
        .in_side   (sq_side),
        .out_valid (rc_valid),
        .out_q     (rc_q),
        .quot      (rc_quot),
        .big       (rc_big),
        .out_side  (rc_side)
    );

    // ---------------------------------------------------------------
    // back stage 1: strength multiply, clamped reciprocals
    // ---------------------------------------------------------------
    logic                   f1_valid_reg;
    logic [7:0]             f1_row_reg;
    logic [7:0]             f1_col_reg;
    logic                   f1_use_prod_reg;
    logic signed [PW-1:0]   f1_val_reg;
    logic signed [PRW-1:0]  f1_prod_reg;

    logic [PW-1:0]          quot_ext;
    logic [PW-1:0]          inv_mag;
    logic [PW-1:0]          neg_mag;
    logic [MW-1:0]          mop;
    logic                   use_prod_next;
    logic signed [PW-1:0]   val_next;

    assign quot_ext = PW'(rc_quot);
    assign inv_mag  = (rc_big || (quot_ext >= pfpg_pkg::INVR_CAP)) ?
                      pfpg_pkg::INVR_CAP : quot_ext;
    assign neg_mag  = (rc_big || (quot_ext >= pfpg_pkg::NEGINVR_CAP)) ?
                      pfpg_pkg::NEGINVR_CAP : quot_ext;

    // cone scales the root, harmonic scales the distance squared in q16
    assign mop = (mode_reg == pfpg_pkg::MODE_CONE) ? MW'(rc_q) : rc_side.hm;

    always_comb
    begin
        use_prod_next = 1'b0;
        val_next      = '0;
        if (rc_side.fixed_sel)
        begin
            val_next = rc_side.fixed_val;
        end
        else
        begin
            case (mode_reg)
                pfpg_pkg::MODE_HARMONIC,
                pfpg_pkg::MODE_CONE:      use_prod_next = 1'b1;
                pfpg_pkg::MODE_INV_R:     val_next = $signed(inv_mag);
                pfpg_pkg::MODE_NEG_INV_R: val_next = -$signed(neg_mag);
                default:                  val_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= rc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_row_reg      <= rc_side.row;
            f1_col_reg      <= rc_side.col;
            f1_use_prod_reg <= use_prod_next;
            f1_val_reg      <= val_next;
            f1_prod_reg     <= strength_reg * $signed({1'b0, mop});
        end
    end

    // ---------------------------------------------------------------
    // back stage 2: floor shift, saturate, output register
    // ---------------------------------------------------------------
    logic [7:0]             cell_row_reg;
    logic [7:0]             cell_col_reg;
    logic signed [PW-1:0]   potential_reg;

    logic signed [PRW-1:0]  shifted;
    logic signed [PW-1:0]   sat_val;
    logic signed [PW-1:0]   potential_next;

    assign shifted = f1_prod_reg >>> 16;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sat_val = PW'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            sat_val = PW'(SAT_LO);
        end
        else
        begin
            sat_val = PW'(shifted);
        end
    end

    assign potential_next = f1_use_prod_reg ? sat_val : f1_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_row_reg  <= f1_row_reg;
            cell_col_reg  <= f1_col_reg;
            potential_reg <= potential_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_row  = cell_row_reg;
    assign cell_col  = cell_col_reg;
    assign potential = potential_reg;

endmodule

`default_nettype wire

// ----- hdl/pfpg_checker.sv -----
// port-level assertions for the potential field pattern generator
`default_nettype none

module pfpg_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [7:0]                   row,
    input wire logic [7:0]                   col,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [7:0]                   cell_row,
    input wire logic [7:0]                   cell_col,
    input wire logic signed [pfpg_pkg::PW-1:0] potential,
    input wire logic                         cfg_valid,
    input wire logic                         cfg_ready,
    input wire logic [pfpg_pkg::RIW-1:0]     cfg_index,
    input wire logic [31:0]                  cfg_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(potential) &&
        $stable(cell_row) && $stable(cell_col))
        else $error("output transaction changed while stalled");

    // a waiting input transaction keeps its cell
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(row) && $stable(col))
        else $error("input transaction changed while waiting");

    // input waits only behind a stuck result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    // a config write carries a known index and value
    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> !$isunknown({cfg_index, cfg_data}))
        else $error("config write with unknown index or data");

endmodule

bind potential_field_pattern_generator_unit pfpg_checker u_pfpg_checker (.*);

`default_nettype wire
